/* rtl/brq_pkg.sv */
`default_nettype none
package brq_pkg;

  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 11;

  localparam logic [CfgIndexW-1:0] CFG_BOOT_REQUEST_CODE  = 3'd0;
  localparam logic [CfgIndexW-1:0] CFG_READ_REQUEST_CODE  = 3'd1;
  localparam logic [CfgIndexW-1:0] CFG_BOOT_COMPLETE_CODE = 3'd2;
  localparam logic [CfgIndexW-1:0] CFG_MIN_BOOT_VERSION   = 3'd3;
  localparam logic [CfgIndexW-1:0] CFG_NOFILE_LENGTH      = 3'd4;

  localparam logic [7:0]  RESET_BOOT_REQUEST_CODE  = 8'd1;
  localparam logic [7:0]  RESET_READ_REQUEST_CODE  = 8'd2;
  localparam logic [7:0]  RESET_BOOT_COMPLETE_CODE = 8'd3;
  localparam logic [7:0]  RESET_MIN_BOOT_VERSION   = 8'd2;
  localparam logic [10:0] RESET_NOFILE_LENGTH      = 11'd0;

  localparam logic [7:0] GROUP_FLAG = 8'h01;

  typedef enum logic [2:0] {
    ST_QUEUED      = 3'd0,
    ST_FULL        = 3'd1,
    ST_BAD_READ    = 3'd2,
    ST_BAD_TYPE    = 3'd3,
    ST_BAD_VERSION = 3'd4,
    ST_DELIVERED   = 3'd5,
    ST_EMPTY       = 3'd6,
    ST_TOO_LONG    = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE      = 2'd0,
    S_OFFER     = 2'd1,
    S_DEQ_CHECK = 2'd2,
    S_DEQ_OUT   = 2'd3
  } state_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  port;
    logic [10:0] length;
    logic [7:0]  packet_type;
    logic [7:0]  version;
    logic [31:0] file_length;
    logic [47:0] source_address;
    logic        dest_group_bit;
    logic [10:0] buffer_limit;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  out_port;
    logic [10:0] out_length;
    logic [7:0]  out_type;
    logic [7:0]  out_version;
    logic [31:0] out_file_length;
    logic [47:0] out_source_address;
  } result_t;

  typedef struct packed {
    logic [47:0] address;
    logic [3:0]  port;
    logic [10:0] length;
    logic [7:0]  packet_type;
    logic [7:0]  version;
    logic [31:0] file_length;
  } entry_t;

  typedef struct packed {
    logic load;
    logic offer;
    logic deq_empty;
    logic deq_read;
    logic deq_out;
  } cmd_t;

  typedef struct packed {
    logic req_kind;
    logic empty;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/brq_ctrl.sv */
`default_nettype none
module brq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire brq_pkg::sts_t sts,
  output brq_pkg::cmd_t      cmd,
  output logic               busy
);

  brq_pkg::state_t state;
  brq_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      brq_pkg::S_IDLE: begin
        if (start) begin
          state_next = sts.req_kind ? brq_pkg::S_DEQ_CHECK : brq_pkg::S_OFFER;
        end
      end
      brq_pkg::S_OFFER: begin
        state_next = brq_pkg::S_IDLE;
      end
      brq_pkg::S_DEQ_CHECK: begin
        state_next = sts.empty ? brq_pkg::S_IDLE : brq_pkg::S_DEQ_OUT;
      end
      brq_pkg::S_DEQ_OUT: begin
        state_next = brq_pkg::S_IDLE;
      end
      default: begin
        state_next = brq_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      brq_pkg::S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      brq_pkg::S_OFFER: begin
        cmd.offer = 1'b1;
      end
      brq_pkg::S_DEQ_CHECK: begin
        cmd.deq_empty = sts.empty;
        cmd.deq_read  = !sts.empty;
      end
      brq_pkg::S_DEQ_OUT: begin
        cmd.deq_out = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/brq_datapath.sv */
`default_nettype none
module brq_datapath #(
  parameter int unsigned QUEUE_DEPTH      = 16,
  parameter int unsigned MAX_PACKET_BYTES = 2047
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire brq_pkg::request_t                request,
  input  wire logic                             cfg_we,
  input  wire logic [brq_pkg::CfgIndexW-1:0]    cfg_index,
  input  wire logic [brq_pkg::CfgDataW-1:0]     cfg_data,
  input  wire brq_pkg::cmd_t                    cmd,
  output brq_pkg::sts_t                         sts,
  output brq_pkg::result_t                      result,
  output logic                                  done
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] LastSlot = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [15:0] MaxBytes = 16'(MAX_PACKET_BYTES);

  logic [7:0]  boot_request_code;
  logic [7:0]  read_request_code;
  logic [7:0]  boot_complete_code;
  logic [7:0]  min_boot_version;
  logic [10:0] nofile_length;

  brq_pkg::request_t req;
  brq_pkg::entry_t   mem [QUEUE_DEPTH];
  brq_pkg::entry_t   rd_data;
  brq_pkg::entry_t   wr_entry;

  logic [PtrW-1:0] read_pointer;
  logic [PtrW-1:0] write_pointer;
  logic [PtrW-1:0] read_pointer_next;
  logic [PtrW-1:0] write_pointer_next;
  logic            queue_full;

  logic            done_next;
  brq_pkg::result_t result_next;

  logic [10:0] len_sat;
  logic        is_boot;
  logic        type_ok;
  logic        offer_ok;
  brq_pkg::status_t offer_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_request_code  <= brq_pkg::RESET_BOOT_REQUEST_CODE;
      read_request_code  <= brq_pkg::RESET_READ_REQUEST_CODE;
      boot_complete_code <= brq_pkg::RESET_BOOT_COMPLETE_CODE;
      min_boot_version   <= brq_pkg::RESET_MIN_BOOT_VERSION;
      nofile_length      <= brq_pkg::RESET_NOFILE_LENGTH;
    end else if (cfg_we) begin
      case (cfg_index)
        brq_pkg::CFG_BOOT_REQUEST_CODE:  boot_request_code  <= cfg_data[7:0];
        brq_pkg::CFG_READ_REQUEST_CODE:  read_request_code  <= cfg_data[7:0];
        brq_pkg::CFG_BOOT_COMPLETE_CODE: boot_complete_code <= cfg_data[7:0];
        brq_pkg::CFG_MIN_BOOT_VERSION:   min_boot_version   <= cfg_data[7:0];
        brq_pkg::CFG_NOFILE_LENGTH:      nofile_length      <= cfg_data[10:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req <= request;
    end
  end

  assign sts.req_kind = request.kind;
  assign sts.empty    = !queue_full && (read_pointer == write_pointer);

  assign read_pointer_next  = (read_pointer == LastSlot) ? '0 : read_pointer + 1'b1;
  assign write_pointer_next = (write_pointer == LastSlot) ? '0 : write_pointer + 1'b1;

  // offer checks
  always_comb begin
    len_sat  = ({5'd0, req.length} > MaxBytes) ? MaxBytes[10:0] : req.length;
    is_boot  = (req.packet_type == boot_request_code);
    type_ok  = is_boot || (req.packet_type == read_request_code)
               || (req.packet_type == boot_complete_code);
    offer_ok = 1'b0;
    if (queue_full) begin
      offer_status = brq_pkg::ST_FULL;
    end else if (req.length == 11'd0) begin
      offer_status = brq_pkg::ST_BAD_READ;
    end else if (!type_ok) begin
      offer_status = brq_pkg::ST_BAD_TYPE;
    end else if (is_boot && (req.version < min_boot_version)) begin
      offer_status = brq_pkg::ST_BAD_VERSION;
    end else begin
      offer_status = brq_pkg::ST_QUEUED;
      offer_ok     = 1'b1;
    end

    wr_entry.address     = {req.source_address[47:41],
                            req.source_address[40] | (req.dest_group_bit & brq_pkg::GROUP_FLAG[0]),
                            req.source_address[39:0]};
    wr_entry.port        = req.port;
    wr_entry.length      = len_sat;
    wr_entry.packet_type = req.packet_type;
    wr_entry.version     = req.version;
    wr_entry.file_length = (is_boot && (len_sat == nofile_length)) ? 32'd0 : req.file_length;
  end

  always_ff @(posedge clk) begin
    if (cmd.offer && offer_ok) begin
      mem[write_pointer] <= wr_entry;
    end
    if (cmd.deq_read) begin
      rd_data <= mem[read_pointer];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer  <= '0;
      write_pointer <= '0;
      queue_full    <= 1'b0;
    end else if (cmd.offer && offer_ok) begin
      write_pointer <= write_pointer_next;
      queue_full    <= (read_pointer == write_pointer_next);
    end else if (cmd.deq_read) begin
      read_pointer <= read_pointer_next;
      queue_full   <= 1'b0;
    end
  end

  always_comb begin
    result_next = '0;
    done_next   = cmd.offer || cmd.deq_empty || cmd.deq_out;
    if (cmd.offer) begin
      result_next.status = offer_status;
    end else if (cmd.deq_empty) begin
      result_next.status = brq_pkg::ST_EMPTY;
    end else if (rd_data.length > req.buffer_limit) begin
      result_next.status     = brq_pkg::ST_TOO_LONG;
      result_next.out_length = rd_data.length;
    end else begin
      result_next.status             = brq_pkg::ST_DELIVERED;
      result_next.out_port           = rd_data.port;
      result_next.out_length         = rd_data.length;
      result_next.out_type           = rd_data.packet_type;
      result_next.out_version        = rd_data.version;
      result_next.out_file_length    = rd_data.file_length;
      result_next.out_source_address = rd_data.address;
    end
  end

  always_ff @(posedge clk) begin
    if (done_next) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= done_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/boot_request_rx_queue_top.sv */
// channel   signals                            transfer when
// -------   --------------------------------   ----------------------
// request   start, busy, request (request_t)   start && !busy at clk
// result    done, result (result_t)            done high, one cycle
// config    cfg_we, cfg_index, cfg_data        cfg_we high at clk
//
// Offer: the request is registered on transfer and checked in S_OFFER; done is
// registered from there. Dequeue passes S_DEQ_CHECK and S_DEQ_OUT before done; an
// empty queue answers from S_DEQ_CHECK like an offer. The extra state is the
// registered read of the entry RAM at the read pointer.
// rst is synchronous, active high; clears pointers and full flag and loads
// the config defaults.
// The receiver cannot stall: done is a one-cycle strobe, and the next
// request may be taken while a result is on the ports.
`default_nettype none
module boot_request_rx_queue_top #(
  parameter int unsigned QUEUE_DEPTH      = 16,
  parameter int unsigned MAX_PACKET_BYTES = 2047
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire brq_pkg::request_t             request,
  output logic                               done,
  output brq_pkg::result_t                   result,
  input  wire logic                          cfg_we,
  input  wire logic [brq_pkg::CfgIndexW-1:0] cfg_index,
  input  wire logic [brq_pkg::CfgDataW-1:0]  cfg_data
);

  brq_pkg::cmd_t cmd;
  brq_pkg::sts_t sts;

  brq_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  brq_datapath #(
    .QUEUE_DEPTH      (QUEUE_DEPTH),
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .result    (result),
    .done      (done)
  );

endmodule
`default_nettype wire

/* bench/boot_request_rx_queue_top_tb.sv */
`timescale 1ns / 1ps

module boot_request_rx_queue_top_tb;

  localparam int unsigned RING_DEPTH    = 16;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned PRINT_CAP     = 200;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          start;
  logic                          busy;
  brq_pkg::request_t             req;
  logic                          done;
  brq_pkg::result_t              res;
  logic                          cfg_we;
  logic [brq_pkg::CfgIndexW-1:0] cfg_index;
  logic [brq_pkg::CfgDataW-1:0]  cfg_data;

  // config and queue state as the block should hold it
  logic [7:0]  cfg_boot_code;
  logic [7:0]  cfg_read_code;
  logic [7:0]  cfg_complete_code;
  logic [7:0]  cfg_min_version;
  logic [10:0] cfg_nofile_length;
  int unsigned ring_head;
  int unsigned ring_tail;
  logic        ring_full;
  brq_pkg::entry_t ring [RING_DEPTH];

  brq_pkg::result_t outcome_q [$];
  int unsigned mismatches = 0;

  boot_request_rx_queue_top u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (req),
    .done      (done),
    .result    (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  task automatic note_mismatch(string msg);
    if (mismatches < PRINT_CAP) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic check_field(string name, logic [47:0] got, logic [47:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %h want %h", name, got, want));
    end
  endtask

  function automatic brq_pkg::result_t predict_outcome(brq_pkg::request_t r);
    brq_pkg::result_t e;
    brq_pkg::entry_t  slot;
    logic             is_boot;
    e = '0;
    if (r.kind == 1'b0) begin
      is_boot = (r.packet_type == cfg_boot_code);
      if (ring_full) begin
        e.status = brq_pkg::ST_FULL;
      end else if (r.length == 11'd0) begin
        e.status = brq_pkg::ST_BAD_READ;
      end else if (!is_boot && r.packet_type != cfg_read_code &&
                   r.packet_type != cfg_complete_code) begin
        e.status = brq_pkg::ST_BAD_TYPE;
      end else if (is_boot && r.version < cfg_min_version) begin
        e.status = brq_pkg::ST_BAD_VERSION;
      end else begin
        slot.address = r.source_address;
        if (r.dest_group_bit) begin
          slot.address[47:40] = slot.address[47:40] | brq_pkg::GROUP_FLAG;
        end
        slot.port        = r.port;
        slot.length      = r.length;
        slot.packet_type = r.packet_type;
        slot.version     = r.version;
        slot.file_length = (is_boot && r.length == cfg_nofile_length) ? 32'd0
                                                                       : r.file_length;
        ring[ring_tail] = slot;
        ring_tail = (ring_tail == RING_DEPTH - 1) ? 0 : ring_tail + 1;
        ring_full = (ring_tail == ring_head);
        e.status = brq_pkg::ST_QUEUED;
      end
    end else begin
      if (!ring_full && ring_head == ring_tail) begin
        e.status = brq_pkg::ST_EMPTY;
      end else begin
        slot = ring[ring_head];
        ring_head = (ring_head == RING_DEPTH - 1) ? 0 : ring_head + 1;
        ring_full = 1'b0;
        e.out_length = slot.length;
        if (slot.length > r.buffer_limit) begin
          e.status = brq_pkg::ST_TOO_LONG;
        end else begin
          e.status             = brq_pkg::ST_DELIVERED;
          e.out_port           = slot.port;
          e.out_type           = slot.packet_type;
          e.out_version        = slot.version;
          e.out_file_length    = slot.file_length;
          e.out_source_address = slot.address;
        end
      end
    end
    return e;
  endfunction

  always @(posedge clk) begin
    brq_pkg::result_t want;
    if (!rst && done === 1'b1) begin
      if (outcome_q.size() == 0) begin
        note_mismatch("result strobed with nothing pending");
      end else begin
        want = outcome_q.pop_front();
        check_field("status", res.status, want.status);
        check_field("out_port", res.out_port, want.out_port);
        check_field("out_length", res.out_length, want.out_length);
        check_field("out_type", res.out_type, want.out_type);
        check_field("out_version", res.out_version, want.out_version);
        check_field("out_file_length", res.out_file_length, want.out_file_length);
        check_field("out_source_address", res.out_source_address,
                    want.out_source_address);
      end
    end
  end

  // returns in the step of the transfer edge with start still high
  task automatic send_request(brq_pkg::request_t r);
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    outcome_q.push_back(predict_outcome(r));
  endtask

  task automatic sender_gap();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 9);
    if (pick < 5) n = 0;
    else if (pick < 9) n = $urandom_range(1, 3);
    else n = $urandom_range(8, 30);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_config(logic [7:0] boot, logic [7:0] rd, logic [7:0] complete,
                                logic [7:0] min_ver, logic [10:0] nofile);
    logic [brq_pkg::CfgIndexW-1:0] regs [5];
    logic [brq_pkg::CfgDataW-1:0]  vals [5];
    regs = '{brq_pkg::CFG_BOOT_REQUEST_CODE, brq_pkg::CFG_READ_REQUEST_CODE,
             brq_pkg::CFG_BOOT_COMPLETE_CODE, brq_pkg::CFG_MIN_BOOT_VERSION,
             brq_pkg::CFG_NOFILE_LENGTH};
    vals = '{{3'd0, boot}, {3'd0, rd}, {3'd0, complete}, {3'd0, min_ver}, nofile};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      case (regs[i])
        brq_pkg::CFG_BOOT_REQUEST_CODE:  cfg_boot_code     = vals[i][7:0];
        brq_pkg::CFG_READ_REQUEST_CODE:  cfg_read_code     = vals[i][7:0];
        brq_pkg::CFG_BOOT_COMPLETE_CODE: cfg_complete_code = vals[i][7:0];
        brq_pkg::CFG_MIN_BOOT_VERSION:   cfg_min_version   = vals[i][7:0];
        brq_pkg::CFG_NOFILE_LENGTH:      cfg_nofile_length = vals[i];
        default: ;
      endcase
    end
    cfg_we <= 1'b0;
  endtask

  function automatic brq_pkg::request_t make_offer(logic [7:0] ptype, logic [7:0] ver,
                                                   logic [10:0] len, logic [31:0] flen,
                                                   logic [47:0] addr, logic grp,
                                                   logic [3:0] prt);
    brq_pkg::request_t r;
    r = '0;
    r.kind           = 1'b0;
    r.packet_type    = ptype;
    r.version        = ver;
    r.length         = len;
    r.file_length    = flen;
    r.source_address = addr;
    r.dest_group_bit = grp;
    r.port           = prt;
    return r;
  endfunction

  function automatic brq_pkg::request_t make_dequeue(logic [10:0] limit);
    brq_pkg::request_t r;
    r = '0;
    r.kind         = 1'b1;
    r.buffer_limit = limit;
    return r;
  endfunction

  function automatic brq_pkg::request_t random_request(bit is_offer);
    brq_pkg::request_t r;
    int unsigned       pick;
    r.kind                  = is_offer ? 1'b0 : 1'b1;
    r.port                  = 4'($urandom);
    r.file_length           = $urandom;
    r.source_address[47:32] = 16'($urandom);
    r.source_address[31:0]  = $urandom;
    r.dest_group_bit        = 1'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 4) r.packet_type = cfg_boot_code;
    else if (pick < 6) r.packet_type = cfg_read_code;
    else if (pick < 8) r.packet_type = cfg_complete_code;
    else r.packet_type = 8'($urandom);
    pick = $urandom_range(0, 3);
    if (pick == 0) r.version = cfg_min_version;
    else if (pick == 1) r.version = cfg_min_version - 8'd1;
    else r.version = 8'($urandom);
    pick = $urandom_range(0, 9);
    case (pick)
      0: r.length = 11'd0;
      1: r.length = cfg_nofile_length;
      2: r.length = 11'd2047;
      3: r.length = 11'd1;
      default: r.length = 11'($urandom_range(1, 2047));
    endcase
    pick = $urandom_range(0, 7);
    if (pick == 0) r.buffer_limit = 11'd0;
    else if (pick == 1) r.buffer_limit = 11'd2047;
    else r.buffer_limit = 11'($urandom);
    return r;
  endfunction

  task automatic test_reset_defaults();
    send_request(make_dequeue(11'd2047));
    send_request(make_offer(brq_pkg::RESET_READ_REQUEST_CODE, 8'd0, 11'd0, 32'hFFFF_FFFF,
                            48'hFFFF_FFFF_FFFF, 1'b1, 4'hF));
    send_request(make_offer(8'h00, 8'd9, 11'd5, 32'd1, 48'd1, 1'b0, 4'h1));
    send_request(make_offer(8'hFF, 8'd9, 11'd5, 32'd1, 48'd1, 1'b0, 4'h1));
    send_request(make_offer(brq_pkg::RESET_BOOT_REQUEST_CODE,
                            brq_pkg::RESET_MIN_BOOT_VERSION - 8'd1,
                            11'd64, 32'd7, 48'd7, 1'b0, 4'h2));
    send_request(make_offer(brq_pkg::RESET_BOOT_REQUEST_CODE,
                            brq_pkg::RESET_MIN_BOOT_VERSION, 11'd2047,
                            32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 4'hF));
    send_request(make_offer(brq_pkg::RESET_READ_REQUEST_CODE, 8'd0, 11'd1, 32'd0, 48'd0,
                            1'b1, 4'h0));
    send_request(make_offer(brq_pkg::RESET_BOOT_COMPLETE_CODE, 8'hFF, 11'd300,
                            32'h1234_5678, 48'h0123_4567_89AB, 1'b0, 4'h5));
    send_request(make_dequeue(11'd2047));
    send_request(make_dequeue(11'd0));
    send_request(make_dequeue(11'd300));
    send_request(make_dequeue(11'd2047));
  endtask

  // first half mostly offers to fill the ring, second half mostly dequeues
  task automatic test_random_traffic(int unsigned count);
    bit gaps_on;
    bit is_offer;
    for (int unsigned i = 0; i < count; i++) begin
      gaps_on  = ((i / 40) % 2) == 1;
      is_offer = $urandom_range(0, 99) < ((i < count / 2) ? 75 : 30);
      send_request(random_request(is_offer));
      if (gaps_on) sender_gap();
    end
  endtask

  task automatic test_overlapping_codes();
    wait_idle();
    program_config(8'd7, 8'd7, 8'd9, 8'h80, 11'd100);
    send_request(make_offer(8'd7, 8'h7F, 11'd100, 32'h1111_2222, 48'h1, 1'b0, 4'h3));
    send_request(make_offer(8'd7, 8'h80, 11'd100, 32'hDEAD_BEEF, 48'hA5A5_5A5A_0001,
                            1'b0, 4'h3));
    send_request(make_offer(8'd9, 8'h00, 11'd100, 32'hCAFE_F00D, 48'h0000_FFFF_0000,
                            1'b1, 4'hC));
    send_request(make_offer(8'd7, 8'hFF, 11'd101, 32'h0BAD_CAFE, 48'hFE00_0000_0000,
                            1'b1, 4'h9));
    send_request(make_offer(8'd8, 8'hFF, 11'd100, 32'd3, 48'd3, 1'b0, 4'h1));
    repeat (4) send_request(make_dequeue(11'd2047));
    test_random_traffic(150);
  endtask

  task automatic test_max_config();
    wait_idle();
    program_config(8'd0, 8'hFF, 8'hFF, 8'hFF, 11'd2047);
    test_random_traffic(150);
  endtask

  task automatic test_min_config();
    wait_idle();
    program_config(8'hFF, 8'd0, 8'd0, 8'd0, 11'd1);
    test_random_traffic(150);
  endtask

  initial begin
    rst       <= 1'b1;
    start     <= 1'b0;
    req       <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    cfg_boot_code     = brq_pkg::RESET_BOOT_REQUEST_CODE;
    cfg_read_code     = brq_pkg::RESET_READ_REQUEST_CODE;
    cfg_complete_code = brq_pkg::RESET_BOOT_COMPLETE_CODE;
    cfg_min_version   = brq_pkg::RESET_MIN_BOOT_VERSION;
    cfg_nofile_length = brq_pkg::RESET_NOFILE_LENGTH;
    ring_head = 0;
    ring_tail = 0;
    ring_full = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_random_traffic(160);
    test_overlapping_codes();
    test_max_config();
    test_min_config();
    wait_idle();

    if (mismatches == 0) begin
      $display("boot_request_rx_queue_top_tb: PASS");
    end else begin
      $display("boot_request_rx_queue_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("boot_request_rx_queue_top_tb: FAIL");
    $finish;
  end

endmodule
